>>> rtl/core/ipv4hb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ipv4hb_pkg;

  localparam int HDR_BYTES = 20;
  localparam int HDR_BITS  = HDR_BYTES * 8;
  localparam int POS_W     = 5;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(HDR_BYTES - 1);

  localparam logic [7:0]  VER_IHL   = 8'h45;
  localparam logic [15:0] HDR_LEN   = 16'd20;
  localparam logic [7:0]  TTL_RESET = 8'd64;

  // register index decoded from paddr[2]
  localparam logic REG_SRC_ADDR = 1'b0;
  localparam logic REG_TTL      = 1'b1;

  typedef struct packed {
    logic [15:0] tot_len;
    logic [7:0]  ttl;
    logic [7:0]  protocol;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
  } csum_in_t;

endpackage

`default_nettype wire

>>> rtl/core/ipv4hb_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ipv4hb_desc_if;
  logic        valid;
  logic        ready;
  logic [15:0] payload_length;
  logic [31:0] destination_address;
  logic [7:0]  protocol_number;

  modport source(output valid, payload_length, destination_address, protocol_number,
                 input ready);
  modport sink(input valid, payload_length, destination_address, protocol_number,
               output ready);
endinterface

interface ipv4hb_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] header_byte;
  logic [4:0] byte_position;
  logic       last_byte;

  modport source(output valid, header_byte, byte_position, last_byte, input ready);
  modport sink(input valid, header_byte, byte_position, last_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/core/ipv4hb_csum.sv
`timescale 1ns / 1ps
`default_nettype none

module ipv4hb_csum
  import ipv4hb_pkg::*;
(
  input  wire csum_in_t fields,
  output logic [15:0]   csum
);

  logic [18:0] sum;
  logic [16:0] fold1;
  logic [15:0] fold2;

  // zero words (id, flags, checksum) drop out of the sum
  always_comb begin
    sum = 19'({VER_IHL, 8'h00})
        + 19'(fields.tot_len)
        + 19'({fields.ttl, fields.protocol})
        + 19'(fields.src_addr[31:16]) + 19'(fields.src_addr[15:0])
        + 19'(fields.dst_addr[31:16]) + 19'(fields.dst_addr[15:0]);
    fold1 = 17'(sum[15:0]) + 17'(sum[18:16]);
    fold2 = fold1[15:0] + 16'(fold1[16]);
    csum  = ~fold2;
  end

endmodule

`default_nettype wire

>>> rtl/core/ipv4_header_builder.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  dir  fields
// desc     in   payload_length, destination_address, protocol_number
// hdr      out  header_byte, byte_position, last_byte
// apb      cfg  0x0 source_address, 0x4 time_to_live
//
// One descriptor gives 20 words, one per cycle while hdr.ready is high;
// the byte shift register sets the rate.
// With the shift register idle, an accepted descriptor goes to the input
// register, then to the shift register, where the first word becomes valid.
// The next descriptor is held in the input register and loads on the cycle
// the last word of the previous header is taken.
// Reset is synchronous: clears valids, source_address to 0, TTL to 64.

module ipv4_header_builder
  import ipv4hb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  ipv4hb_desc_if.sink      desc,
  ipv4hb_byte_if.source    hdr,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [31:0] src_addr;
  logic [7:0]  ttl;

  logic        in_valid;
  logic [15:0] in_total;
  logic [31:0] in_dst;
  logic [7:0]  in_proto;

  logic                hdr_valid;
  logic [HDR_BITS-1:0] hdr_shift;
  logic [POS_W-1:0]    pos;

  logic     cfg_wr;
  logic     in_fire;
  logic     out_fire;
  logic     out_done;
  logic     load;
  csum_in_t csum_fields;
  logic [15:0] csum;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_TTL) ? {24'h0, ttl} : src_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_addr <= '0;
      ttl      <= TTL_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_SRC_ADDR: src_addr <= pwdata;
        REG_TTL:      ttl      <= pwdata[7:0];
        default:      ;
      endcase
    end
  end

  assign out_fire = hdr_valid && hdr.ready;
  assign out_done = out_fire && (pos == LAST_POS);
  assign load     = in_valid && (!hdr_valid || out_done);
  assign in_fire  = desc.valid && desc.ready;
  assign desc.ready = !in_valid || load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_fire) begin
      in_valid <= 1'b1;
    end else if (load) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_total <= desc.payload_length + HDR_LEN;
      in_dst   <= desc.destination_address;
      in_proto <= desc.protocol_number;
    end
  end

  assign csum_fields = '{tot_len: in_total, ttl: ttl, protocol: in_proto,
                         src_addr: src_addr, dst_addr: in_dst};

  ipv4hb_csum u_csum (
    .fields (csum_fields),
    .csum   (csum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_valid <= 1'b0;
      pos       <= '0;
    end else if (load) begin
      hdr_valid <= 1'b1;
      pos       <= '0;
    end else if (out_done) begin
      hdr_valid <= 1'b0;
      pos       <= '0;
    end else if (out_fire) begin
      pos <= pos + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hdr_shift <= {VER_IHL, 8'h00, in_total, 32'h0, ttl, in_proto, csum,
                    src_addr, in_dst};
    end else if (out_fire) begin
      hdr_shift <= {hdr_shift[HDR_BITS-9:0], 8'h00};
    end
  end

  assign hdr.valid         = hdr_valid;
  assign hdr.header_byte   = hdr_shift[HDR_BITS-1 -: 8];
  assign hdr.byte_position = pos;
  assign hdr.last_byte     = (pos == LAST_POS);

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    hdr_valid |-> (pos <= LAST_POS))
    else $error("byte position past end of header");

  a_load_start: assert property (@(posedge clk) disable iff (rst)
    load |=> (hdr_valid && (pos == '0)))
    else $error("header load did not restart at byte 0");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (out_done && !load) |=> !hdr_valid)
    else $error("header still valid after last word");

  a_hold_desc: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !load) |=> in_valid)
    else $error("pending descriptor dropped");

endmodule

`default_nettype wire
